/* sv/psc_pkg.sv */
// Shared types, codes and constants of the pilot stick command state machine.
package psc_pkg;

    localparam int unsigned StickWidth  = 12;
    localparam int unsigned BaroWidth   = 24;
    localparam int unsigned SonarWidth  = 10;
    localparam int unsigned CfgIdxWidth = 2;

    localparam int unsigned InDataWidth  = 120;
    localparam int unsigned OutDataWidth = 64;

    localparam logic [StickWidth-1:0] SwitchOnBelow = 12'd1750;
    localparam logic [StickWidth-1:0] ModeAttAbove  = 12'd1500;

    localparam logic [StickWidth-1:0] StickLowReset  = 12'd1100;
    localparam logic [StickWidth-1:0] StickHighReset = 12'd1900;
    localparam logic [StickWidth-1:0] ArmedThrReset  = 12'd1150;

    localparam logic [CfgIdxWidth-1:0] CfgStickLow  = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CfgStickHigh = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CfgArmedThr  = 2'd2;

    localparam logic [1:0] HoldOff   = 2'd0;
    localparam logic [1:0] HoldOn    = 2'd1;
    localparam logic [1:0] HoldPanic = 2'd2;

    localparam logic [1:0] MotorNone     = 2'd0;
    localparam logic [1:0] MotorArmed    = 2'd1;
    localparam logic [1:0] MotorDisarmed = 2'd2;

    typedef struct packed {
        logic [StickWidth-1:0] stick_low;
        logic [StickWidth-1:0] stick_high;
        logic [StickWidth-1:0] armed_thr;
    } cfg_t;

    typedef struct packed {
        logic                  panic_set;
        logic [SonarWidth-1:0] sonar_range;
        logic signed [BaroWidth-1:0] baro_altitude;
        logic [StickWidth-1:0] landing_switch;
        logic [StickWidth-1:0] hold_switch;
        logic [StickWidth-1:0] mode_switch;
        logic [StickWidth-1:0] yaw_stick;
        logic [StickWidth-1:0] pitch_stick;
        logic [StickWidth-1:0] roll_stick;
        logic [StickWidth-1:0] throttle_stick;
    } frame_t;

    typedef struct packed {
        logic                  armed;
        logic                  safety_latch;
        logic                  flying;
        logic                  prev_mode;
        logic [1:0]            hold_state;
        logic                  hold_captured;
        logic                  landing_state;
        logic                  landing_captured;
        logic signed [BaroWidth-1:0] baro_target;
        logic [SonarWidth-1:0] sonar_target;
        logic [StickWidth-1:0] hold_throttle;
    } state_t;

    typedef struct packed {
        logic [StickWidth-1:0] hold_throttle_out;
        logic [SonarWidth-1:0] sonar_target_out;
        logic signed [BaroWidth-1:0] baro_target_out;
        logic                  hold_pid_reset;
        logic                  autoland_active;
        logic [1:0]            hold_state_out;
        logic                  zero_integral_request;
        logic                  calibrate_request;
        logic [1:0]            motor_event;
        logic                  attitude_mode;
        logic                  in_flight;
        logic                  armed;
    } result_t;

endpackage

/* sv/psc_cfg.sv */
// Threshold configuration registers.
module psc_cfg
    import psc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [StickWidth-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_low  <= StickLowReset;
            cfg_reg.stick_high <= StickHighReset;
            cfg_reg.armed_thr  <= ArmedThrReset;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CfgStickLow:  cfg_reg.stick_low  <= cfg_data;
                CfgStickHigh: cfg_reg.stick_high <= cfg_data;
                CfgArmedThr:  cfg_reg.armed_thr  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/psc_logic.sv */
// Per-frame stick command, mode, hold and landing logic.
module psc_logic
    import psc_pkg::*;
(
    input  cfg_t    cfg,
    input  frame_t  frame,
    input  state_t  state,
    output state_t  state_next,
    output result_t result
);

    always_comb
    begin
        state_t     s;
        logic [1:0] ev;
        logic       calib;
        logic       zero_int;
        logic       pid_reset;
        logic       att;
        logic       capture;

        s         = state;
        ev        = MotorNone;
        calib     = 1'b0;
        zero_int  = 1'b0;
        pid_reset = 1'b0;
        capture   = 1'b0;

        if (frame.panic_set)
        begin
            s.hold_state = HoldPanic;
        end

        if (frame.throttle_stick < cfg.stick_low)
        begin
            if (frame.yaw_stick < cfg.stick_low && s.armed)
            begin
                ev       = MotorDisarmed;
                s.armed  = 1'b0;
                s.flying = 1'b0;
            end
            if (frame.yaw_stick < cfg.stick_low && frame.roll_stick > cfg.stick_high &&
                frame.pitch_stick < cfg.stick_low)
            begin
                calib    = 1'b1;
                zero_int = 1'b1;
            end
            if (frame.yaw_stick > cfg.stick_high && !s.armed && s.safety_latch)
            begin
                ev       = MotorArmed;
                s.armed  = 1'b1;
                zero_int = 1'b1;
            end
            if (frame.yaw_stick > cfg.stick_low)
            begin
                s.safety_latch = 1'b1;
            end
        end

        if (!s.flying && s.armed && frame.throttle_stick > cfg.armed_thr)
        begin
            s.flying = 1'b1;
        end

        att = frame.mode_switch > ModeAttAbove;
        if (att != s.prev_mode)
        begin
            zero_int    = 1'b1;
            s.prev_mode = att;
        end

        if (frame.hold_switch < SwitchOnBelow)
        begin
            if (s.hold_state != HoldPanic)
            begin
                if (!s.hold_captured)
                begin
                    capture         = 1'b1;
                    s.hold_captured = 1'b1;
                end
                s.hold_state = HoldOn;
            end
        end
        else
        begin
            s.hold_captured = 1'b0;
            s.hold_state    = HoldOff;
        end

        if (frame.landing_switch < SwitchOnBelow)
        begin
            if (s.hold_state != HoldPanic)
            begin
                if (!s.landing_captured)
                begin
                    s.landing_state    = 1'b1;
                    capture            = 1'b1;
                    s.landing_captured = 1'b1;
                end
                s.hold_state = HoldOn;
            end
        end
        else
        begin
            s.landing_state    = 1'b0;
            s.landing_captured = 1'b0;
            if (frame.hold_switch > SwitchOnBelow)
            begin
                s.hold_state    = HoldOff;
                s.hold_captured = 1'b0;
            end
        end

        if (capture)
        begin
            pid_reset       = 1'b1;
            s.baro_target   = frame.baro_altitude;
            s.sonar_target  = frame.sonar_range;
            s.hold_throttle = frame.throttle_stick;
        end

        state_next = s;

        result.armed                 = s.armed;
        result.in_flight             = s.flying;
        result.attitude_mode         = att;
        result.motor_event           = ev;
        result.calibrate_request     = calib;
        result.zero_integral_request = zero_int;
        result.hold_state_out        = s.hold_state;
        result.autoland_active       = s.landing_state;
        result.hold_pid_reset        = pid_reset;
        result.baro_target_out       = s.baro_target;
        result.sonar_target_out      = s.sonar_target;
        result.hold_throttle_out     = s.hold_throttle;
    end

endmodule

/* sv/pilot_stick_command_state_machine.sv */
// Top level of the pilot stick command state machine.
// The block takes one receiver frame per clock while results are taken, and returns one
// result item for each frame: a frame is first captured in an input register, then the
// stick, mode, hold and landing logic updates the flight state and loads the result
// register in a single pass. While a result waits, the input register can still take
// one more frame; after that the input stalls until the result is taken. The user must
// write thresholds through the configuration channel only while no frame is in progress;
// the block itself does not enforce this.
module pilot_stick_command_state_machine
    import psc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Fields from bit 0: throttle_stick, roll_stick, pitch_stick, yaw_stick,
    // mode_switch, hold_switch, landing_switch, baro_altitude, sonar_range,
    // panic_set, zero fill.
    input  logic [InDataWidth-1:0]  s_tdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // Fields from bit 0: armed, in_flight, attitude_mode, motor_event,
    // calibrate_request, zero_integral_request, hold_state_out,
    // autoland_active, hold_pid_reset, baro_target_out, sonar_target_out,
    // hold_throttle_out, zero fill.
    output logic [OutDataWidth-1:0] m_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [StickWidth-1:0]   cfg_data
);

    localparam int unsigned FrameBits  = $bits(frame_t);
    localparam int unsigned ResultBits = $bits(result_t);

    cfg_t    cfg;
    frame_t  frame_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    advance;
    logic    in_accept;

    psc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    psc_logic u_logic (
        .cfg        (cfg),
        .frame      (frame_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            frame_reg <= frame_t'(s_tdata[FrameBits-1:0]);
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataWidth - ResultBits){1'b0}}, result_reg};

    a_flight_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && result_reg.in_flight |-> result_reg.armed)
        else $error("in_flight reported while disarmed");

    a_arm_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && result_reg.motor_event == MotorArmed
        |-> result_reg.armed && result_reg.zero_integral_request)
        else $error("arming event without armed state and integrator reset");

    a_calib_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && result_reg.calibrate_request |-> result_reg.zero_integral_request)
        else $error("calibration without integrator reset");

    a_landing_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && result_reg.autoland_active |-> result_reg.hold_state_out != HoldOff)
        else $error("auto landing active with hold off");

    a_state_moves_with_item: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("flight state changed without a frame");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the pilot stick command state machine.
`timescale 1ns / 100ps

module tb;
    import psc_pkg::*;

    localparam int ClkPeriod     = 12;
    localparam int WatchdogLimit = 2000;
    localparam int StallCycles   = 80;
    localparam int Mid           = 1500;
    localparam int SwOn          = 0;
    localparam int SwOff         = 4095;

    typedef struct {
        logic                        armed;
        logic                        latch;
        logic                        flying;
        logic                        att_prev;
        logic [1:0]                  hold;
        logic                        hold_cap;
        logic                        landing;
        logic                        land_cap;
        logic signed [BaroWidth-1:0] baro;
        logic [SonarWidth-1:0]       sonar;
        logic [StickWidth-1:0]       thr;
    } craft_state_t;

    typedef struct {
        frame_t  frame;
        bit      pinned;
        result_t want;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n;
    logic [InDataWidth-1:0]  s_tdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [OutDataWidth-1:0] m_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CfgIdxWidth-1:0]  cfg_index;
    logic [StickWidth-1:0]   cfg_data;

    // Directed rows may carry a typed expectation that travels with the item.
    bit      s_pinned;
    result_t s_pinned_res;

    craft_state_t          craft;
    logic [StickWidth-1:0] lim_low;
    logic [StickWidth-1:0] lim_high;
    logic [StickWidth-1:0] lim_armed;
    result_t               status_due[$];
    stim_row_t             dir_rows[$];

    bit gaps_on;
    bit stall_req;
    int stall_left;
    int fail_count;
    int frames_in;
    int results_out;
    int arms;
    int disarms;
    int calibs;
    int captures;
    int panics;

    logic [StickWidth-1:0] hold_pos;
    logic [StickWidth-1:0] land_pos;
    logic [StickWidth-1:0] mode_pos;

    pilot_stick_command_state_machine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(ClkPeriod / 2) clk = ~clk;

    function automatic result_t next_flight_status(input frame_t f);
        result_t r;
        logic    att;
        r = '0;
        if (f.panic_set)
            craft.hold = HoldPanic;
        if (f.throttle_stick < lim_low)
        begin
            if (f.yaw_stick < lim_low && craft.armed)
            begin
                r.motor_event = MotorDisarmed;
                craft.armed   = 1'b0;
                craft.flying  = 1'b0;
            end
            if (f.yaw_stick < lim_low && f.roll_stick > lim_high && f.pitch_stick < lim_low)
            begin
                r.calibrate_request     = 1'b1;
                r.zero_integral_request = 1'b1;
            end
            if (f.yaw_stick > lim_high && !craft.armed && craft.latch)
            begin
                r.motor_event           = MotorArmed;
                craft.armed             = 1'b1;
                r.zero_integral_request = 1'b1;
            end
            if (f.yaw_stick > lim_low)
                craft.latch = 1'b1;
        end
        if (!craft.flying && craft.armed && f.throttle_stick > lim_armed)
            craft.flying = 1'b1;
        att = f.mode_switch > ModeAttAbove;
        if (att != craft.att_prev)
        begin
            r.zero_integral_request = 1'b1;
            craft.att_prev          = att;
        end
        if (f.hold_switch < SwitchOnBelow)
        begin
            if (craft.hold != HoldPanic)
            begin
                if (!craft.hold_cap)
                begin
                    craft.baro       = f.baro_altitude;
                    craft.sonar      = f.sonar_range;
                    craft.thr        = f.throttle_stick;
                    r.hold_pid_reset = 1'b1;
                    craft.hold_cap   = 1'b1;
                end
                craft.hold = HoldOn;
            end
        end
        else
        begin
            craft.hold_cap = 1'b0;
            craft.hold     = HoldOff;
        end
        if (f.landing_switch < SwitchOnBelow)
        begin
            if (craft.hold != HoldPanic)
            begin
                if (!craft.land_cap)
                begin
                    craft.landing    = 1'b1;
                    craft.baro       = f.baro_altitude;
                    craft.sonar      = f.sonar_range;
                    craft.thr        = f.throttle_stick;
                    r.hold_pid_reset = 1'b1;
                    craft.land_cap   = 1'b1;
                end
                craft.hold = HoldOn;
            end
        end
        else
        begin
            craft.landing  = 1'b0;
            craft.land_cap = 1'b0;
            if (f.hold_switch > SwitchOnBelow)
            begin
                craft.hold     = HoldOff;
                craft.hold_cap = 1'b0;
            end
        end
        r.armed             = craft.armed;
        r.in_flight         = craft.flying;
        r.attitude_mode     = att;
        r.hold_state_out    = craft.hold;
        r.autoland_active   = craft.landing;
        r.baro_target_out   = craft.baro;
        r.sonar_target_out  = craft.sonar;
        r.hold_throttle_out = craft.thr;
        return r;
    endfunction

    function automatic frame_t mk_frame(input int thr, input int roll, input int pitch,
                                        input int yaw, input int mode, input int hold,
                                        input int land, input int baro, input int sonar,
                                        input bit panic);
        frame_t f;
        f.throttle_stick = StickWidth'(thr);
        f.roll_stick     = StickWidth'(roll);
        f.pitch_stick    = StickWidth'(pitch);
        f.yaw_stick      = StickWidth'(yaw);
        f.mode_switch    = StickWidth'(mode);
        f.hold_switch    = StickWidth'(hold);
        f.landing_switch = StickWidth'(land);
        f.baro_altitude  = BaroWidth'(baro);
        f.sonar_range    = SonarWidth'(sonar);
        f.panic_set      = panic;
        return f;
    endfunction

    function automatic void add_row(input frame_t f, input bit pinned, input result_t want);
        stim_row_t row;
        row.frame  = f;
        row.pinned = pinned;
        row.want   = want;
        dir_rows.push_back(row);
    endfunction

    // Values cluster around the two thresholds and the ends of the range.
    function automatic logic [StickWidth-1:0] pick_level(input int a, input int b);
        int v;
        case ($urandom_range(0, 5))
            0:       v = a + int'($urandom_range(0, 2)) - 1;
            1:       v = b + int'($urandom_range(0, 2)) - 1;
            2:       v = 0;
            3:       v = 4095;
            default: v = int'($urandom_range(0, 4095));
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return StickWidth'(v);
    endfunction

    // Switches mostly keep their position so that hold and landing sequences run on.
    function automatic frame_t rand_frame();
        frame_t f;
        if ($urandom_range(0, 99) < 12)
            hold_pos = pick_level(SwitchOnBelow, SwitchOnBelow);
        if ($urandom_range(0, 99) < 12)
            land_pos = pick_level(SwitchOnBelow, SwitchOnBelow);
        if ($urandom_range(0, 99) < 10)
            mode_pos = pick_level(ModeAttAbove, ModeAttAbove);
        f.throttle_stick = ($urandom_range(0, 99) < 40) ? StickWidth'($urandom_range(0, lim_low))
                                                        : pick_level(lim_low, lim_armed);
        f.roll_stick     = pick_level(lim_low, lim_high);
        f.pitch_stick    = pick_level(lim_low, lim_high);
        f.yaw_stick      = pick_level(lim_low, lim_high);
        f.mode_switch    = mode_pos;
        f.hold_switch    = hold_pos;
        f.landing_switch = land_pos;
        f.baro_altitude  = BaroWidth'($urandom);
        f.sonar_range    = SonarWidth'($urandom_range(0, 1023));
        f.panic_set      = $urandom_range(0, 99) < 4;
        return f;
    endfunction

    task automatic send_frame(input frame_t f, input bit pinned, input result_t want);
        while (gaps_on && $urandom_range(0, 99) < 19)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid     <= 1'b1;
        s_tdata      <= InDataWidth'(f);
        s_pinned     <= pinned;
        s_pinned_res <= want;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (status_due.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= StickWidth'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic load_thresholds(input int lo, input int hi, input int armed_thr);
        write_reg(CfgStickLow, lo);
        write_reg(CfgStickHigh, hi);
        write_reg(CfgArmedThr, armed_thr);
        cfg_valid <= 1'b0;
    endtask

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH: %s", what);
    endtask

    task automatic check_field(input string name, input logic [23:0] got,
                               input logic [23:0] want);
        if (got !== want)
            note_failure($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                                   results_out, name, want, got));
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CfgStickLow:  lim_low   = cfg_data;
                    CfgStickHigh: lim_high  = cfg_data;
                    CfgArmedThr:  lim_armed = cfg_data;
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                want = next_flight_status(frame_t'(s_tdata[$bits(frame_t)-1:0]));
                if (s_pinned)
                    want = s_pinned_res;
                status_due.push_back(want);
                frames_in++;
                arms     += (want.motor_event == MotorArmed);
                disarms  += (want.motor_event == MotorDisarmed);
                calibs   += want.calibrate_request;
                captures += want.hold_pid_reset;
                panics   += s_tdata[$bits(frame_t)-1];
            end
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                results_out++;
                if (status_due.size() == 0)
                    note_failure($sformatf("result %0d arrived with none expected", results_out));
                else
                begin
                    want = status_due.pop_front();
                    check_field("armed", got.armed, want.armed);
                    check_field("in_flight", got.in_flight, want.in_flight);
                    check_field("attitude_mode", got.attitude_mode, want.attitude_mode);
                    check_field("motor_event", got.motor_event, want.motor_event);
                    check_field("calibrate_request", got.calibrate_request,
                                want.calibrate_request);
                    check_field("zero_integral_request", got.zero_integral_request,
                                want.zero_integral_request);
                    check_field("hold_state_out", got.hold_state_out, want.hold_state_out);
                    check_field("autoland_active", got.autoland_active, want.autoland_active);
                    check_field("hold_pid_reset", got.hold_pid_reset, want.hold_pid_reset);
                    check_field("baro_target_out", got.baro_target_out, want.baro_target_out);
                    check_field("sonar_target_out", got.sonar_target_out,
                                want.sonar_target_out);
                    check_field("hold_throttle_out", got.hold_throttle_out,
                                want.hold_throttle_out);
                end
            end
        end
    end

    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                stall_left = StallCycles;
                stall_req  = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(gaps_on && $urandom_range(0, 99) < 19);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WatchdogLimit)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int lo_set[7];
        int hi_set[7];
        int arm_set[7];
        int count_set[7];
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tdata      = '0;
        s_tvalid     = 1'b0;
        s_pinned     = 1'b0;
        s_pinned_res = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CfgStickLow;
        cfg_data     = '0;
        gaps_on      = 1'b1;
        stall_req    = 1'b0;
        fail_count   = 0;
        frames_in    = 0;
        results_out  = 0;
        arms         = 0;
        disarms      = 0;
        calibs       = 0;
        captures     = 0;
        panics       = 0;
        craft        = '{default: '0};
        lim_low      = StickLowReset;
        lim_high     = StickHighReset;
        lim_armed    = ArmedThrReset;
        hold_pos     = StickWidth'(SwOff);
        land_pos     = StickWidth'(SwOff);
        mode_pos     = StickWidth'(Mid);

        lo_set    = '{1100, 0, 4095, 4095, 0, 1900, 0};
        hi_set    = '{1900, 0, 4095, 0, 4095, 1100, 0};
        arm_set   = '{1150, 0, 4095, 0, 4095, 1500, 0};
        count_set = '{300, 120, 120, 120, 120, 150, 150};

        // The first rows run on the reset thresholds and check reset state.
        add_row(mk_frame(0, Mid, Mid, Mid, 0, SwOff, SwOff, 0, 0, 0), 1'b1, '0);
        add_row(mk_frame(0, Mid, Mid, 4095, 0, SwOff, SwOff, 0, 0, 0), 1'b1,
                result_t'{armed: 1'b1, motor_event: MotorArmed,
                          zero_integral_request: 1'b1, default: '0});
        add_row(mk_frame(4095, 0, 0, Mid, 0, SwOff, SwOff, 0, 0, 0), 1'b1,
                result_t'{armed: 1'b1, in_flight: 1'b1, default: '0});
        add_row(mk_frame(4095, 4095, 4095, Mid, 4095, SwOff, SwOff, 0, 0, 0), 1'b1,
                result_t'{armed: 1'b1, in_flight: 1'b1, attitude_mode: 1'b1,
                          zero_integral_request: 1'b1, default: '0});
        add_row(mk_frame(4095, Mid, Mid, Mid, 4095, SwOn, SwOff, -8388608, 1023, 0), 1'b1,
                result_t'{armed: 1'b1, in_flight: 1'b1, attitude_mode: 1'b1,
                          hold_state_out: HoldOn, hold_pid_reset: 1'b1,
                          baro_target_out: -24'sd8388608, sonar_target_out: 10'd1023,
                          hold_throttle_out: 12'd4095, default: '0});
        // Hold stays captured, then panic blocks both captures until the switches release.
        add_row(mk_frame(0, Mid, Mid, Mid, 4095, SwOn, SwOff, 8388607, 0, 0), 1'b0, '0);
        add_row(mk_frame(2000, Mid, Mid, Mid, 4095, SwOn, SwOff, 123, 45, 1), 1'b0, '0);
        add_row(mk_frame(2000, Mid, Mid, Mid, 4095, SwOn, SwOn, 321, 54, 0), 1'b0, '0);
        add_row(mk_frame(2000, Mid, Mid, Mid, 4095, 1750, SwOn, 77, 512, 0), 1'b0, '0);
        add_row(mk_frame(2000, Mid, Mid, Mid, 4095, SwOn, SwOn, -5, 700, 0), 1'b0, '0);
        add_row(mk_frame(2000, Mid, Mid, Mid, 4095, SwOn, SwOff, 99, 9, 0), 1'b0, '0);
        add_row(mk_frame(2000, Mid, Mid, Mid, 4095, 1751, SwOff, 11, 1, 0), 1'b0, '0);
        // Stick commands right at the thresholds.
        add_row(mk_frame(1100, Mid, Mid, 0, 4095, SwOff, SwOff, 0, 0, 0), 1'b0, '0);
        add_row(mk_frame(1099, 4095, 0, 0, 4095, SwOff, SwOff, 0, 0, 0), 1'b0, '0);
        add_row(mk_frame(0, Mid, Mid, 1900, 4095, SwOff, SwOff, 0, 0, 0), 1'b0, '0);
        add_row(mk_frame(0, Mid, Mid, 1901, 4095, SwOff, SwOff, 0, 0, 0), 1'b0, '0);
        add_row(mk_frame(1150, Mid, Mid, Mid, 4095, SwOff, SwOff, 0, 0, 0), 1'b0, '0);
        add_row(mk_frame(1151, Mid, Mid, Mid, 4095, SwOff, SwOff, 0, 0, 0), 1'b0, '0);
        add_row(mk_frame(1151, Mid, Mid, Mid, 1500, SwOff, SwOff, 0, 0, 0), 1'b0, '0);
        add_row(mk_frame(1151, Mid, Mid, Mid, 1501, SwOff, SwOff, 0, 0, 0), 1'b0, '0);
        add_row(mk_frame(1151, Mid, Mid, Mid, 1501, SwOff, SwOff, 0, 0, 1), 1'b0, '0);
        add_row(mk_frame(0, 1901, 1099, 1099, 1501, SwOff, SwOff, 0, 0, 0), 1'b0, '0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_frame(dir_rows[i].frame, dir_rows[i].pinned, dir_rows[i].want);

        for (int p = 0; p < 7; p++)
        begin
            wait_drained();
            if (p == 6)
                load_thresholds($urandom_range(0, 4095), $urandom_range(0, 4095),
                                $urandom_range(0, 4095));
            else
                load_thresholds(lo_set[p], hi_set[p], arm_set[p]);
            for (int n = 0; n < count_set[p]; n++)
            begin
                if (p == 0 && n == 40)
                    stall_req = 1'b1;
                if (p == 0 && n == 100)
                    gaps_on = 1'b0;
                if (p == 0 && n == 150)
                    wait_drained();
                if (p == 0 && n == 250)
                    gaps_on = 1'b1;
                send_frame(rand_frame(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (5) @(negedge clk);
        $display("Ran %0d frames over 7 threshold settings, extremes and crossed ones included.",
                 frames_in);
        $display("Saw %0d arms, %0d disarms, %0d calibrations, %0d captures, %0d panic frames.",
                 arms, disarms, calibs, captures, panics);
        if (fail_count == 0 && status_due.size() == 0 && results_out == frames_in)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
